@@ src/multi_slot_software_timer_unit_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_UNIT_MACROS_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MSSU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mssu_pkg.sv @@
package mssu_pkg;

	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = 5;
	localparam int CPM_W     = 10;
	localparam int US_W      = 22;
	localparam int CNT_W     = 21;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_CREATE    = 3'd1,
		OP_START     = 3'd2,
		OP_STOP      = 3'd3,
		OP_DESTROY   = 3'd4,
		OP_PAUSE     = 3'd5,
		OP_RESUME    = 3'd6,
		OP_RESET_ALL = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOT_USED = 2'd1,
		STAT_ZERO_INT = 2'd2,
		STAT_IN_USE   = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD_RD,
		S_CMD_EX,
		S_TICK_DIV,
		S_WALK_RD,
		S_WALK_EX,
		S_WALK_DIV,
		S_WALK_END,
		S_RST_RD,
		S_RST_EX
	} seq_state_t;

	// decoded command word passed from front to back
	typedef struct packed {
		op_t         op;
		logic [2:0]  slot;
		logic        exists;
		logic        periodic;
		logic [31:0] val;
		logic [19:0] cycles;
	} cmd_word_t;

	// result word
	typedef struct packed {
		logic             kind;
		logic [2:0]       slot;
		logic [CNT_W-1:0] count;
		stat_t            status;
		logic             last;
	} res_word_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ src/mssu_div.sv @@
module mssu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mssu_pkg::div_req_t req,
	output mssu_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic [mssu_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [mssu_pkg::DIV_W-1:0]      quot_q;
	logic [mssu_pkg::DIV_W-1:0]      rem_q;
	logic [mssu_pkg::DIV_W-1:0]      dvs_q;
	logic [mssu_pkg::DIV_W:0]        shifted;
	logic [mssu_pkg::DIV_W:0]        diff;
	logic                            take;

	// one restoring step per cycle
	always_comb begin
		shifted = {rem_q, quot_q[mssu_pkg::DIV_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		take    = (shifted >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[mssu_pkg::DIV_W-2:0], take};
			rem_q  <= take ? diff[mssu_pkg::DIV_W-1:0] : shifted[mssu_pkg::DIV_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

@@ src/mssu_front.sv @@
module mssu_front #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          cmd,
	input  logic [2:0]          slot,
	input  logic                timer_periodic,
	input  logic [31:0]         interval_or_delay,
	input  logic [19:0]         cycles,
	output logic                cmd_valid,
	output mssu_pkg::cmd_word_t cmd_word,
	input  logic                cmd_take
);

	mssu_pkg::cmd_word_t q_mem [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	mssu_pkg::cmd_word_t dec;
	logic                wr_en;
	logic                rd_en;

	// decode the incoming word
	always_comb begin
		dec.op       = mssu_pkg::op_t'(cmd);
		dec.slot     = slot;
		dec.exists   = (32'(slot) < NUM_SLOTS);
		dec.periodic = timer_periodic;
		dec.val      = interval_or_delay;
		dec.cycles   = cycles;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_word  = q_mem[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

endmodule

@@ src/mssu_back.sv @@
module mssu_back #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mssu_pkg::CPM_W-1:0]   cpm,
	input  logic                         cmd_valid,
	input  mssu_pkg::cmd_word_t          cmd_word,
	output logic                         cmd_take,
	output mssu_pkg::div_req_t           div_req,
	input  mssu_pkg::div_rsp_t           div_rsp,
	output logic                         empty,
	input  logic                         pop,
	output mssu_pkg::res_word_t          res
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

	mssu_pkg::seq_state_t state_q, state_d;

	// slot state
	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] per_q;
	logic [31:0]          int_mem [NUM_SLOTS];
	logic [31:0]          cd_mem  [NUM_SLOTS];
	logic [31:0]          rd_int_q;
	logic [31:0]          rd_cd_q;

	mssu_pkg::cmd_word_t          cur_q;
	logic [SLOT_W-1:0]            idx_q;
	logic [5:0]                   idx_ext;
	logic [mssu_pkg::US_W-1:0]    us_q;
	logic [mssu_pkg::CPM_W-1:0]   rem_q;
	logic                         paused_q;
	logic                         pend_v_q;
	logic [2:0]                   pend_slot_q;
	logic [mssu_pkg::CNT_W-1:0]   pend_cnt_q;

	// output queue
	mssu_pkg::res_word_t of_mem [2];
	logic                of_wr_q;
	logic                of_rd_q;
	logic [1:0]          of_cnt_q;
	logic                of_full;
	logic                of_push;
	logic                of_pop;
	mssu_pkg::res_word_t of_data;

	// sequencer strobes
	logic                       int_we;
	logic                       cd_we;
	logic [31:0]                cd_wd;
	logic                       rpt;
	logic [mssu_pkg::CNT_W-1:0] rpt_cnt;
	logic                       adv;
	logic                       clr_act;
	logic                       used_ok;
	logic                       cd_hit;
	mssu_pkg::stat_t            st;
	logic [31:0]                cpm_eff;

	assign idx_ext = 6'(idx_q);
	assign of_full = (of_cnt_q == 2'd2);
	assign empty   = (of_cnt_q == 2'd0);
	assign of_pop  = pop && !empty;
	assign res     = of_mem[of_rd_q];
	assign used_ok = cur_q.exists && used_q[idx_q];
	assign cd_hit  = ({10'd0, us_q} >= rd_cd_q);
	assign cpm_eff = (cpm == '0) ? 32'd1 : 32'(cpm);

	// command status code
	always_comb begin
		case (cur_q.op)
			mssu_pkg::OP_CREATE: begin
				if (!cur_q.exists) st = mssu_pkg::STAT_NOT_USED;
				else if (used_q[idx_q]) st = mssu_pkg::STAT_IN_USE;
				else if (cur_q.val == '0) st = mssu_pkg::STAT_ZERO_INT;
				else st = mssu_pkg::STAT_OK;
			end
			mssu_pkg::OP_START, mssu_pkg::OP_STOP, mssu_pkg::OP_DESTROY: begin
				st = used_ok ? mssu_pkg::STAT_OK : mssu_pkg::STAT_NOT_USED;
			end
			default: st = mssu_pkg::STAT_OK;
		endcase
	end

	// next state and strobes
	always_comb begin
		state_d          = state_q;
		cmd_take         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = 32'(cur_q.cycles) + 32'(rem_q);
		div_req.divisor  = cpm_eff;
		of_push          = 1'b0;
		of_data.kind     = mssu_pkg::KIND_FIRE;
		of_data.slot     = pend_slot_q;
		of_data.count    = pend_cnt_q;
		of_data.status   = mssu_pkg::STAT_OK;
		of_data.last     = 1'b0;
		int_we           = 1'b0;
		cd_we            = 1'b0;
		cd_wd            = cur_q.val;
		rpt              = 1'b0;
		rpt_cnt          = 21'd1;
		adv              = 1'b0;
		clr_act          = 1'b0;
		case (state_q)
			mssu_pkg::S_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					case (cmd_word.op)
						mssu_pkg::OP_TICK: begin
							if (!paused_q) begin
								div_req.start    = 1'b1;
								div_req.dividend = 32'(cmd_word.cycles) + 32'(rem_q);
								state_d          = mssu_pkg::S_TICK_DIV;
							end
						end
						mssu_pkg::OP_RESET_ALL: state_d = mssu_pkg::S_RST_RD;
						default: state_d = mssu_pkg::S_CMD_RD;
					endcase
				end
			end
			mssu_pkg::S_CMD_RD: state_d = mssu_pkg::S_CMD_EX;
			mssu_pkg::S_CMD_EX: begin
				if (!of_full) begin
					of_push        = 1'b1;
					of_data.kind   = mssu_pkg::KIND_STATUS;
					of_data.count  = '0;
					of_data.status = st;
					of_data.last   = 1'b1;
					of_data.slot   = (cur_q.op == mssu_pkg::OP_CREATE ||
						cur_q.op == mssu_pkg::OP_START || cur_q.op == mssu_pkg::OP_STOP ||
						cur_q.op == mssu_pkg::OP_DESTROY) ? cur_q.slot : 3'd0;
					if (st == mssu_pkg::STAT_OK && cur_q.op == mssu_pkg::OP_CREATE) begin
						int_we = 1'b1;
						cd_we  = 1'b1;
					end
					if (st == mssu_pkg::STAT_OK && cur_q.op == mssu_pkg::OP_START) begin
						cd_we = 1'b1;
						cd_wd = (cur_q.val != '0) ? cur_q.val : rd_int_q;
					end
					state_d = mssu_pkg::S_IDLE;
				end
			end
			mssu_pkg::S_TICK_DIV: begin
				if (!div_rsp.busy) state_d = mssu_pkg::S_WALK_RD;
			end
			mssu_pkg::S_WALK_RD: begin
				if (active_q[idx_q]) state_d = mssu_pkg::S_WALK_EX;
				else adv = 1'b1;
			end
			mssu_pkg::S_WALK_EX: begin
				if (cd_hit) begin
					if (per_q[idx_q] && rd_int_q != '0) begin
						div_req.start    = 1'b1;
						div_req.dividend = 32'(us_q) - rd_cd_q;
						div_req.divisor  = rd_int_q;
						state_d          = mssu_pkg::S_WALK_DIV;
					end else if (!(pend_v_q && of_full)) begin
						rpt     = 1'b1;
						clr_act = 1'b1;
						adv     = 1'b1;
					end
				end else begin
					cd_we = 1'b1;
					cd_wd = rd_cd_q - 32'(us_q);
					adv   = 1'b1;
				end
			end
			mssu_pkg::S_WALK_DIV: begin
				if (!div_rsp.busy && !(pend_v_q && of_full)) begin
					rpt     = 1'b1;
					rpt_cnt = div_rsp.quot[mssu_pkg::CNT_W-1:0] + 21'd1;
					cd_we   = 1'b1;
					cd_wd   = rd_int_q - div_rsp.rem;
					adv     = 1'b1;
				end
			end
			mssu_pkg::S_WALK_END: begin
				if (!pend_v_q) begin
					state_d = mssu_pkg::S_IDLE;
				end else if (!of_full) begin
					of_push      = 1'b1;
					of_data.last = 1'b1;
					state_d      = mssu_pkg::S_IDLE;
				end
			end
			mssu_pkg::S_RST_RD: state_d = mssu_pkg::S_RST_EX;
			mssu_pkg::S_RST_EX: begin
				if (used_q[idx_q]) begin
					cd_we = 1'b1;
					cd_wd = rd_int_q;
				end
				state_d = (idx_q == LAST_IDX) ? mssu_pkg::S_CMD_EX : mssu_pkg::S_RST_RD;
			end
			default: state_d = mssu_pkg::S_IDLE;
		endcase
		// flush the held report when a new one arrives
		if (rpt && pend_v_q) of_push = 1'b1;
		if (adv) begin
			state_d = (idx_q == LAST_IDX) ? mssu_pkg::S_WALK_END : mssu_pkg::S_WALK_RD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mssu_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// control and flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			active_q <= '0;
			per_q    <= '0;
			rem_q    <= '0;
			paused_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (state_q == mssu_pkg::S_TICK_DIV && !div_rsp.busy) begin
				rem_q <= div_rsp.rem[mssu_pkg::CPM_W-1:0];
			end
			if (state_q == mssu_pkg::S_RST_EX && used_q[idx_q]) begin
				active_q[idx_q] <= 1'b0;
			end
			if (clr_act) active_q[idx_q] <= 1'b0;
			if (rpt) pend_v_q <= 1'b1;
			else if (state_q == mssu_pkg::S_WALK_END && of_push) pend_v_q <= 1'b0;
			if (state_q == mssu_pkg::S_CMD_EX && of_push) begin
				case (cur_q.op)
					mssu_pkg::OP_CREATE: begin
						if (st == mssu_pkg::STAT_OK) begin
							used_q[idx_q]   <= 1'b1;
							active_q[idx_q] <= 1'b0;
							per_q[idx_q]    <= cur_q.periodic;
						end
					end
					mssu_pkg::OP_START: if (st == mssu_pkg::STAT_OK) active_q[idx_q] <= 1'b1;
					mssu_pkg::OP_STOP: if (st == mssu_pkg::STAT_OK) active_q[idx_q] <= 1'b0;
					mssu_pkg::OP_DESTROY: begin
						if (st == mssu_pkg::STAT_OK) begin
							used_q[idx_q]   <= 1'b0;
							active_q[idx_q] <= 1'b0;
						end
					end
					mssu_pkg::OP_PAUSE: paused_q <= 1'b1;
					mssu_pkg::OP_RESUME: paused_q <= 1'b0;
					mssu_pkg::OP_RESET_ALL: begin
						paused_q <= 1'b0;
						rem_q    <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers and slot memories
	always_ff @(posedge clk) begin
		rd_int_q <= int_mem[idx_q];
		rd_cd_q  <= cd_mem[idx_q];
		if (int_we) int_mem[idx_q] <= cur_q.val;
		if (cd_we) cd_mem[idx_q] <= cd_wd;
		if (cmd_take) begin
			cur_q <= cmd_word;
			idx_q <= (cmd_word.op == mssu_pkg::OP_RESET_ALL) ? '0 : SLOT_W'(cmd_word.slot);
		end else if (state_q == mssu_pkg::S_TICK_DIV) begin
			idx_q <= '0;
		end else if ((adv || state_q == mssu_pkg::S_RST_EX) && idx_q != LAST_IDX) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == mssu_pkg::S_TICK_DIV && !div_rsp.busy) begin
			us_q <= div_rsp.quot[mssu_pkg::US_W-1:0];
		end
		if (rpt) begin
			pend_slot_q <= idx_ext[2:0];
			pend_cnt_q  <= rpt_cnt;
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wr_q  <= 1'b0;
			of_rd_q  <= 1'b0;
			of_cnt_q <= 2'd0;
		end else begin
			if (of_push) of_wr_q <= !of_wr_q;
			if (of_pop) of_rd_q <= !of_rd_q;
			if (of_push && !of_pop) of_cnt_q <= of_cnt_q + 2'd1;
			else if (of_pop && !of_push) of_cnt_q <= of_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (of_push) of_mem[of_wr_q] <= of_data;
	end

endmodule

@@ src/multi_slot_software_timer_unit.sv @@
// Timer unit with NUM_SLOTS periodic or one-shot slots. Commands enter a
// two-word queue and are executed one at a time by a sequencer; results
// leave through a two-word queue. A tick, unless paused, converts cycles
// to microseconds in a shared one-bit-per-cycle divider, then walks every
// slot in turn; an expiring periodic slot needs the same divider again,
// and a final step closes the walk.
module multi_slot_software_timer_unit #(
	parameter int NUM_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [2:0]  slot,
	input  logic        timer_periodic,
	input  logic [31:0] interval_or_delay,
	input  logic [19:0] cycles,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [2:0]  fired_slot,
	output logic [20:0] fire_count,
	output logic [1:0]  status,
	output logic        last
);

	logic [mssu_pkg::CPM_W-1:0] cpm_q;
	logic                       cmd_valid;
	logic                       cmd_take;
	mssu_pkg::cmd_word_t        cmd_word;
	mssu_pkg::div_req_t         div_req;
	mssu_pkg::div_rsp_t         div_rsp;
	mssu_pkg::res_word_t        res;

	// cycles-per-microsecond register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cpm_q <= 10'd5;
		else if (cfg_we) cpm_q <= cfg_wdata;
	end

	mssu_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.cmd               (cmd),
		.slot              (slot),
		.timer_periodic    (timer_periodic),
		.interval_or_delay (interval_or_delay),
		.cycles            (cycles),
		.cmd_valid         (cmd_valid),
		.cmd_word          (cmd_word),
		.cmd_take          (cmd_take)
	);

	mssu_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cpm       (cpm_q),
		.cmd_valid (cmd_valid),
		.cmd_word  (cmd_word),
		.cmd_take  (cmd_take),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	mssu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign kind       = res.kind;
	assign fired_slot = res.slot;
	assign fire_count = res.count;
	assign status     = res.status;
	assign last       = res.last;

endmodule

@@ src/mssu_checker.sv @@
`include "multi_slot_software_timer_unit_macros.svh"

module mssu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [2:0]  fired_slot,
	input logic [20:0] fire_count,
	input logic [1:0]  status,
	input logic        last
);

	// a status word closes its command and carries no count
	`MSSU_ASSERT_IMPL(a_status_word, !empty && kind == mssu_pkg::KIND_STATUS, fire_count == 21'd0 && last, "status word malformed")

	// a firing report has ok status and at least one expiry
	`MSSU_ASSERT_IMPL(a_fire_word, !empty && kind == mssu_pkg::KIND_FIRE, status == mssu_pkg::STAT_OK && fire_count != 21'd0, "firing report malformed")

	// a waiting word holds until taken
	`MSSU_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(fired_slot) && $stable(fire_count) && $stable(last), "result changed while stalled")

endmodule

bind multi_slot_software_timer_unit mssu_checker u_mssu_checker (.*);
